FILE: hw/rtl/msie_pkg.sv
// ----------------------------------------------------------------------------
// msie_pkg
// Shared types and constants of the MIPS-subset instruction executor.
// ----------------------------------------------------------------------------
package msie_pkg;

  // Default depth of the halfword memory
  localparam int MEM_HALVES_DEF = 4096;

  // Request types
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_EXEC = 1'b1;

  // Opcodes
  localparam logic [5:0] OP_RTYPE = 6'd0;
  localparam logic [5:0] OP_J     = 6'd2;
  localparam logic [5:0] OP_BEQ   = 6'd4;
  localparam logic [5:0] OP_ADDI  = 6'd8;
  localparam logic [5:0] OP_LH    = 6'd33;
  localparam logic [5:0] OP_LW    = 6'd35;
  localparam logic [5:0] OP_SH    = 6'd41;
  localparam logic [5:0] OP_SW    = 6'd43;

  // R-type function codes
  localparam logic [5:0] FN_ADD = 6'd32;
  localparam logic [5:0] FN_SUB = 6'd34;

  // Bits of the PC kept by a jump
  localparam logic [31:0] PC_KEEP_MASK = 32'hF800_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LMOD,
    ST_PCMOD,
    ST_FETCH_HI,
    ST_FETCH_LO,
    ST_DECODE,
    ST_EXEC,
    ST_EAMOD,
    ST_LD_A,
    ST_LD_B,
    ST_ST_LO,
    ST_FINISH
  } state_t;

endpackage

FILE: hw/rtl/msie_if.sv
// ----------------------------------------------------------------------------
// msie_if
// Valid/ready channels of the executor: request in, result out.
// ----------------------------------------------------------------------------
interface msie_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [11:0] load_addr;
  logic [15:0] load_value;

  modport source (output valid, output req_type, output load_addr, output load_value,
                  input ready);
  modport sink (input valid, input req_type, input load_addr, input load_value,
                output ready);
endinterface

interface msie_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] pc_after;
  logic [31:0] instr_word;
  logic        bad_instr;
  logic        reg_written;
  logic [4:0]  dest_index;
  logic [31:0] dest_value;
  logic        mem_written;

  modport source (output valid, output pc_after, output instr_word, output bad_instr,
                  output reg_written, output dest_index, output dest_value,
                  output mem_written, input ready);
  modport sink (input valid, input pc_after, input instr_word, input bad_instr,
                input reg_written, input dest_index, input dest_value,
                input mem_written, output ready);
endinterface

FILE: hw/rtl/msie_ram.sv
// ----------------------------------------------------------------------------
// msie_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module msie_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = msie_pkg::MEM_HALVES_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/msie_mod.sv
// ----------------------------------------------------------------------------
// msie_mod
// Reduces a 32-bit address modulo the memory depth. Power-of-two depth is a
// mask (result registered in the cycle after start); otherwise restoring
// reduction, four bits a cycle.
// ----------------------------------------------------------------------------
module msie_mod #(
  parameter int MEM_HALVES = msie_pkg::MEM_HALVES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [31:0]                   value,
  output logic                          done,
  output logic [$clog2(MEM_HALVES)-1:0] res
);

  localparam int AW = $clog2(MEM_HALVES);

  generate
    if ((MEM_HALVES & (MEM_HALVES - 1)) == 0) begin : g_mask
      logic          done_r;
      logic [AW-1:0] res_r;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          done_r <= 1'b0;
        end else begin
          done_r <= start;
        end
        if (start) begin
          res_r <= value[AW-1:0];
        end
      end

      assign done = done_r;
      assign res  = res_r;
    end else begin : g_iter
      localparam int          StepBits = 4;
      localparam int          Cycles   = 32 / StepBits;
      localparam int          CntW     = $clog2(Cycles);
      localparam logic [AW:0] ModW     = (AW + 1)'(MEM_HALVES);

      logic            busy_r, busy_nxt;
      logic            done_r, done_nxt;
      logic [CntW-1:0] cnt_r, cnt_nxt;
      logic [31:0]     shift_r, shift_nxt;
      logic [AW-1:0]   rem_r, rem_nxt;
      logic [AW-1:0]   rem_w;
      logic [AW:0]     t;

      // Restoring steps over the next few bits, MSB first
      always_comb begin
        rem_w = rem_r;
        t     = '0;
        for (int k = 0; k < StepBits; k++) begin
          t = {rem_w, shift_r[31-k]};
          if (t >= ModW) begin
            t = t - ModW;
          end
          rem_w = t[AW-1:0];
        end
      end

      always_comb begin
        busy_nxt  = busy_r;
        done_nxt  = 1'b0;
        cnt_nxt   = cnt_r;
        shift_nxt = shift_r;
        rem_nxt   = rem_r;
        if (start) begin
          busy_nxt  = 1'b1;
          cnt_nxt   = '0;
          shift_nxt = value;
          rem_nxt   = '0;
        end else if (busy_r) begin
          rem_nxt   = rem_w;
          shift_nxt = shift_r << StepBits;
          cnt_nxt   = cnt_r + 1'b1;
          if (cnt_r == CntW'(Cycles - 1)) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          busy_r <= 1'b0;
          done_r <= 1'b0;
        end else begin
          busy_r <= busy_nxt;
          done_r <= done_nxt;
        end
        cnt_r   <= cnt_nxt;
        shift_r <= shift_nxt;
        rem_r   <= rem_nxt;
      end

      assign done = done_r;
      assign res  = rem_r;
    end
  endgenerate

endmodule

FILE: hw/rtl/mips_subset_instruction_executor.sv
// ----------------------------------------------------------------------------
// mips_subset_instruction_executor
// MIPS-subset core over a halfword memory: boot-image loads and execution.
// ----------------------------------------------------------------------------
// One request is taken at a time: in_req.ready is high only in the idle state,
// and a result waits in FINISH until the output register is free. The
// sequencer works around the single read port of the halfword memory: an
// instruction is fetched as two halfwords, LH reads one, LW two, SH writes one
// and SW two. Other depths use the iterative address reduction. After reset the
// halfword memory is cleared with in_req.ready low.
module mips_subset_instruction_executor #(
  parameter int MEM_HALVES = msie_pkg::MEM_HALVES_DEF
) (
  input logic         clk,
  input logic         rst_n,
  msie_req_if.sink    in_req,
  msie_res_if.source  out_res
);

  localparam int AW = $clog2(MEM_HALVES);

  msie_pkg::state_t state_r, state_nxt;

  logic [31:0]   pc_r, pc_nxt;
  logic [31:0]   pc_tgt_r, pc_tgt_nxt;
  logic [31:0]   ir_r, ir_nxt;
  logic [31:0]   rt_val_r, rt_val_nxt;
  logic [15:0]   hi_r, hi_nxt;
  logic [15:0]   ld_val_r, ld_val_nxt;
  logic [AW-1:0] idx_r, idx_nxt, idx_inc;

  logic          res_wr_r, res_wr_nxt;
  logic          res_mem_r, res_mem_nxt;
  logic          res_bad_r, res_bad_nxt;
  logic [4:0]    res_dest_r, res_dest_nxt;
  logic [31:0]   res_val_r, res_val_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_pc_r, out_pc_nxt;
  logic [31:0]   out_ir_r, out_ir_nxt;
  logic          out_bad_r, out_bad_nxt;
  logic          out_wr_r, out_wr_nxt;
  logic [4:0]    out_dest_r, out_dest_nxt;
  logic [31:0]   out_val_r, out_val_nxt;
  logic          out_mem_r, out_mem_nxt;

  logic          clr_r, clr_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [31:0]   rf_valid_r, rf_valid_nxt;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [15:0]   mem_wdata, mem_rdata;

  logic          rf_we;
  logic [4:0]    rf_waddr, rf_raddr_a, rf_raddr_b;
  logic [31:0]   rf_wdata, rf_rdata_a, rf_rdata_b;

  logic          mod_start, mod_done;
  logic [31:0]   mod_val;
  logic [AW-1:0] mod_res;

  logic [31:0]   rs_v, rt_v, imm_sx, pc_inc, ea;
  logic [5:0]    op;
  logic          wr_eff, out_free, take_out, in_take;

  msie_ram #(.WIDTH(16), .DEPTH(MEM_HALVES)) u_half_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Two copies of the register file give both source reads in the same cycle
  msie_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .raddr (rf_raddr_a),
    .rdata (rf_rdata_a)
  );

  msie_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .raddr (rf_raddr_b),
    .rdata (rf_rdata_b)
  );

  msie_mod #(.MEM_HALVES(MEM_HALVES)) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .value (mod_val),
    .done  (mod_done),
    .res   (mod_res)
  );

  // Never-written registers read as zero
  assign rs_v    = rf_valid_r[ir_r[25:21]] ? rf_rdata_a : 32'd0;
  assign rt_v    = rf_valid_r[ir_r[20:16]] ? rf_rdata_b : 32'd0;
  assign imm_sx  = {{16{ir_r[15]}}, ir_r[15:0]};
  assign ea      = rs_v + imm_sx;
  assign pc_inc  = pc_r + 32'd2;
  assign op      = ir_r[31:26];
  assign idx_inc = (idx_r == AW'(MEM_HALVES - 1)) ? '0 : idx_r + 1'b1;

  assign wr_eff   = res_wr_r && (res_dest_r != 5'd0);
  assign take_out = out_valid_r && out_res.ready;
  assign out_free = !out_valid_r || out_res.ready;

  assign in_req.ready = (state_r == msie_pkg::ST_IDLE) && !clr_r;
  assign in_take      = in_req.valid && in_req.ready;

  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    pc_tgt_nxt    = pc_tgt_r;
    ir_nxt        = ir_r;
    rt_val_nxt    = rt_val_r;
    hi_nxt        = hi_r;
    ld_val_nxt    = ld_val_r;
    idx_nxt       = idx_r;
    res_wr_nxt    = res_wr_r;
    res_mem_nxt   = res_mem_r;
    res_bad_nxt   = res_bad_r;
    res_dest_nxt  = res_dest_r;
    res_val_nxt   = res_val_r;
    out_valid_nxt = take_out ? 1'b0 : out_valid_r;
    out_pc_nxt    = out_pc_r;
    out_ir_nxt    = out_ir_r;
    out_bad_nxt   = out_bad_r;
    out_wr_nxt    = out_wr_r;
    out_dest_nxt  = out_dest_r;
    out_val_nxt   = out_val_r;
    out_mem_nxt   = out_mem_r;
    clr_nxt       = clr_r;
    clr_cnt_nxt   = clr_cnt_r;
    rf_valid_nxt  = rf_valid_r;

    mem_we     = 1'b0;
    mem_waddr  = idx_r;
    mem_wdata  = rt_val_r[15:0];
    mem_raddr  = idx_r;
    rf_we      = 1'b0;
    rf_waddr   = res_dest_r;
    rf_wdata   = res_val_r;
    rf_raddr_a = ir_r[25:21];
    rf_raddr_b = ir_r[20:16];
    mod_start  = 1'b0;
    mod_val    = pc_r;

    // Clearing pass after reset
    if (clr_r) begin
      mem_we      = 1'b1;
      mem_waddr   = clr_cnt_r;
      mem_wdata   = 16'd0;
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == AW'(MEM_HALVES - 1)) begin
        clr_nxt = 1'b0;
      end
    end

    case (state_r)
      msie_pkg::ST_IDLE: begin
        if (in_take) begin
          res_wr_nxt   = 1'b0;
          res_mem_nxt  = 1'b0;
          res_bad_nxt  = 1'b0;
          res_dest_nxt = 5'd0;
          res_val_nxt  = 32'd0;
          mod_start    = 1'b1;
          if (in_req.req_type == msie_pkg::REQ_LOAD) begin
            mod_val    = 32'(in_req.load_addr);
            ld_val_nxt = in_req.load_value;
            ir_nxt     = 32'd0;
            pc_tgt_nxt = pc_r;
            state_nxt  = msie_pkg::ST_LMOD;
          end else begin
            state_nxt = msie_pkg::ST_PCMOD;
          end
        end
      end
      msie_pkg::ST_LMOD: begin
        if (mod_done) begin
          mem_we    = 1'b1;
          mem_waddr = mod_res;
          mem_wdata = ld_val_r;
          state_nxt = msie_pkg::ST_FINISH;
        end
      end
      msie_pkg::ST_PCMOD: begin
        if (mod_done) begin
          idx_nxt   = mod_res;
          state_nxt = msie_pkg::ST_FETCH_HI;
        end
      end
      msie_pkg::ST_FETCH_HI: begin
        state_nxt = msie_pkg::ST_FETCH_LO;
      end
      msie_pkg::ST_FETCH_LO: begin
        mem_raddr = idx_inc;
        hi_nxt    = mem_rdata;
        state_nxt = msie_pkg::ST_DECODE;
      end
      msie_pkg::ST_DECODE: begin
        ir_nxt     = {hi_r, mem_rdata};
        rf_raddr_a = ir_nxt[25:21];
        rf_raddr_b = ir_nxt[20:16];
        state_nxt  = msie_pkg::ST_EXEC;
      end
      msie_pkg::ST_EXEC: begin
        pc_tgt_nxt = pc_inc;
        rt_val_nxt = rt_v;
        state_nxt  = msie_pkg::ST_FINISH;
        case (op)
          msie_pkg::OP_RTYPE: begin
            if (ir_r[5:0] == msie_pkg::FN_ADD) begin
              res_wr_nxt   = 1'b1;
              res_dest_nxt = ir_r[15:11];
              res_val_nxt  = rs_v + rt_v;
            end else if (ir_r[5:0] == msie_pkg::FN_SUB) begin
              res_wr_nxt   = 1'b1;
              res_dest_nxt = ir_r[15:11];
              res_val_nxt  = rs_v - rt_v;
            end else begin
              res_bad_nxt = 1'b1;
            end
          end
          msie_pkg::OP_ADDI: begin
            res_wr_nxt   = 1'b1;
            res_dest_nxt = ir_r[20:16];
            res_val_nxt  = ea;
          end
          msie_pkg::OP_LW, msie_pkg::OP_LH: begin
            res_dest_nxt = ir_r[20:16];
            mod_start    = 1'b1;
            mod_val      = ea;
            state_nxt    = msie_pkg::ST_EAMOD;
          end
          msie_pkg::OP_SW, msie_pkg::OP_SH: begin
            mod_start = 1'b1;
            mod_val   = ea;
            state_nxt = msie_pkg::ST_EAMOD;
          end
          msie_pkg::OP_BEQ: begin
            if (rs_v == rt_v) begin
              pc_tgt_nxt = pc_inc + {imm_sx[30:0], 1'b0};
            end
          end
          msie_pkg::OP_J: begin
            pc_tgt_nxt = (pc_inc & msie_pkg::PC_KEEP_MASK) | {5'd0, ir_r[25:0], 1'b0};
          end
          default: begin
            res_bad_nxt = 1'b1;
          end
        endcase
      end
      msie_pkg::ST_EAMOD: begin
        if (mod_done) begin
          idx_nxt = mod_res;
          case (op)
            msie_pkg::OP_LW, msie_pkg::OP_LH: begin
              mem_raddr = mod_res;
              state_nxt = msie_pkg::ST_LD_A;
            end
            msie_pkg::OP_SH: begin
              mem_we      = 1'b1;
              mem_waddr   = mod_res;
              mem_wdata   = rt_val_r[15:0];
              res_mem_nxt = 1'b1;
              state_nxt   = msie_pkg::ST_FINISH;
            end
            msie_pkg::OP_SW: begin
              mem_we      = 1'b1;
              mem_waddr   = mod_res;
              mem_wdata   = rt_val_r[31:16];
              res_mem_nxt = 1'b1;
              state_nxt   = msie_pkg::ST_ST_LO;
            end
            default: begin
              state_nxt = msie_pkg::ST_FINISH;
            end
          endcase
        end
      end
      msie_pkg::ST_LD_A: begin
        if (op == msie_pkg::OP_LH) begin
          res_wr_nxt  = 1'b1;
          res_val_nxt = {{16{mem_rdata[15]}}, mem_rdata};
          state_nxt   = msie_pkg::ST_FINISH;
        end else begin
          hi_nxt    = mem_rdata;
          mem_raddr = idx_inc;
          state_nxt = msie_pkg::ST_LD_B;
        end
      end
      msie_pkg::ST_LD_B: begin
        res_wr_nxt  = 1'b1;
        res_val_nxt = {hi_r, mem_rdata};
        state_nxt   = msie_pkg::ST_FINISH;
      end
      msie_pkg::ST_ST_LO: begin
        mem_we    = 1'b1;
        mem_waddr = idx_inc;
        mem_wdata = rt_val_r[15:0];
        state_nxt = msie_pkg::ST_FINISH;
      end
      msie_pkg::ST_FINISH: begin
        // Commit only once the output register is free
        if (out_free) begin
          rf_we = wr_eff;
          if (wr_eff) begin
            rf_valid_nxt[res_dest_r] = 1'b1;
          end
          pc_nxt        = pc_tgt_r;
          out_valid_nxt = 1'b1;
          out_pc_nxt    = pc_tgt_r;
          out_ir_nxt    = ir_r;
          out_bad_nxt   = res_bad_r;
          out_wr_nxt    = wr_eff;
          out_dest_nxt  = wr_eff ? res_dest_r : 5'd0;
          out_val_nxt   = wr_eff ? res_val_r : 32'd0;
          out_mem_nxt   = res_mem_r;
          state_nxt     = msie_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = msie_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= msie_pkg::ST_IDLE;
      pc_r        <= 32'd0;
      out_valid_r <= 1'b0;
      clr_r       <= 1'b1;
      clr_cnt_r   <= '0;
      rf_valid_r  <= 32'd0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
      clr_r       <= clr_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      rf_valid_r  <= rf_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pc_tgt_r   <= pc_tgt_nxt;
    ir_r       <= ir_nxt;
    rt_val_r   <= rt_val_nxt;
    hi_r       <= hi_nxt;
    ld_val_r   <= ld_val_nxt;
    idx_r      <= idx_nxt;
    res_wr_r   <= res_wr_nxt;
    res_mem_r  <= res_mem_nxt;
    res_bad_r  <= res_bad_nxt;
    res_dest_r <= res_dest_nxt;
    res_val_r  <= res_val_nxt;
    out_pc_r   <= out_pc_nxt;
    out_ir_r   <= out_ir_nxt;
    out_bad_r  <= out_bad_nxt;
    out_wr_r   <= out_wr_nxt;
    out_dest_r <= out_dest_nxt;
    out_val_r  <= out_val_nxt;
    out_mem_r  <= out_mem_nxt;
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.pc_after    = out_pc_r;
  assign out_res.instr_word  = out_ir_r;
  assign out_res.bad_instr   = out_bad_r;
  assign out_res.reg_written = out_wr_r;
  assign out_res.dest_index  = out_dest_r;
  assign out_res.dest_value  = out_val_r;
  assign out_res.mem_written = out_mem_r;

endmodule

FILE: hw/rtl/msie_checker.sv
// ----------------------------------------------------------------------------
// msie_checker
// Port-level assertions on the executor, bound to the top level.
// ----------------------------------------------------------------------------
module msie_checker (
  input logic         clk,
  input logic         rst_n,
  msie_req_if.sink    in_req,
  msie_res_if.source  out_res
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && !out_res.ready |=> out_res.valid && $stable(out_res.pc_after)
      && $stable(out_res.instr_word) && $stable(out_res.dest_value))
    else $error("result changed while stalled");

  // Memory clearing keeps the request side closed after reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_req.ready)
    else $error("request accepted during memory clear");

  // One transaction at a time in the sequencer
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.valid && in_req.ready |=> !in_req.ready)
    else $error("request taken while previous one in progress");

  // PC only ever moves in whole words
  a_pc_even: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid |-> !out_res.pc_after[0])
    else $error("odd program counter");

  // An unsupported instruction writes neither a register nor memory
  a_bad_no_effect: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.bad_instr |-> !out_res.reg_written && !out_res.mem_written
      && (out_res.dest_value == 32'd0))
    else $error("unsupported instruction had an effect");

endmodule

bind mips_subset_instruction_executor msie_checker u_msie_checker (
  .clk     (clk),
  .rst_n   (rst_n),
  .in_req  (in_req),
  .out_res (out_res)
);
